@@ hw/rtl/sorted_timer_queue_unit_defines.svh @@
// Assertion macros shared by the sorted timer queue RTL.
`ifndef SORTED_TIMER_QUEUE_UNIT_DEFINES_SVH
`define SORTED_TIMER_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define STQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define STQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/stq_pkg.sv @@
// Types and constants shared by the sorted timer queue modules.
`default_nettype none

package stq_pkg;

    localparam int ID_W        = 4;
    localparam int ID_NUM      = 2 ** ID_W;
    localparam int TIME_W      = 32;
    localparam int MODE_W      = 2;
    localparam int MAX_RESULTS = 16;
    localparam int POP_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD    = 2'd0,
        MODE_ADJUST = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_TICK   = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_ADJ_CHK,
        ST_RM_RD,
        ST_RM_MV,
        ST_INS_RD,
        ST_INS_CMP,
        ST_TK_HEAD,
        ST_TK_CHK,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] expiry;
    } entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/stq_req_if.sv @@
// Request channel interface of the sorted timer queue.
`default_nettype none

interface stq_req_if;
    logic                        valid;
    logic                        ready;
    logic [stq_pkg::MODE_W-1:0]  mode;
    logic [stq_pkg::ID_W-1:0]    timer_id;
    logic [stq_pkg::TIME_W-1:0]  expire_time;
    logic [stq_pkg::TIME_W-1:0]  now;

    modport source (output valid, mode, timer_id, expire_time, now, input ready);
    modport sink (input valid, mode, timer_id, expire_time, now, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/stq_rsp_if.sv @@
// Result channel interface of the sorted timer queue.
`default_nettype none

interface stq_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [stq_pkg::ID_W-1:0]  result_id;
    logic                      expired;
    logic                      status;
    logic                      last;

    modport source (output valid, result_id, expired, status, last, input ready);
    modport sink (input valid, result_id, expired, status, last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/stq_list_ram.sv @@
// Ordered list memory: one write and one registered read per cycle.
`default_nettype none

module stq_list_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic [AW-1:0]   waddr,
    input  wire stq_pkg::entry_t wdata,
    input  wire logic            re,
    input  wire logic [AW-1:0]   raddr,
    output stq_pkg::entry_t      rdata
);

    stq_pkg::entry_t mem [DEPTH];
    stq_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/stq_seq.sv @@
// Sequencer that walks the ordered list for add, adjust, delete and tick.
`default_nettype none

module stq_seq #(
    parameter int NUM_TIMERS = 16,
    parameter int AW         = $clog2(NUM_TIMERS)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    stq_req_if.sink                  req,
    stq_rsp_if.source                rsp,
    output logic                     ram_we,
    output logic [AW-1:0]            ram_waddr,
    output stq_pkg::entry_t          ram_wdata,
    output logic                     ram_re,
    output logic [AW-1:0]            ram_raddr,
    input  wire stq_pkg::entry_t     ram_rdata
);

    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int XW = CW + 1;

    stq_pkg::state_t                 state_reg, state_next;
    stq_pkg::mode_t                  mode_reg, mode_next;
    logic [stq_pkg::ID_W-1:0]        id_reg, id_next;
    logic [stq_pkg::TIME_W-1:0]      exp_reg, exp_next;
    logic [stq_pkg::TIME_W-1:0]      now_reg, now_next;
    logic [stq_pkg::TIME_W-1:0]      prev_exp_reg, prev_exp_next;
    logic [AW-1:0]                   ptr_reg, ptr_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic [stq_pkg::ID_NUM-1:0]      act_reg, act_next;
    logic [stq_pkg::POP_W-1:0]       pops_reg, pops_next;
    logic [stq_pkg::ID_W-1:0]        pend_id_reg, pend_id_next;
    logic                            st_reg, st_next;

    logic                            ov_reg;
    logic [stq_pkg::ID_W-1:0]        o_id_reg;
    logic                            o_exp_reg;
    logic                            o_st_reg;
    logic                            o_last_reg;

    logic                            emit;
    logic [stq_pkg::ID_W-1:0]        em_id;
    logic                            em_exp;
    logic                            em_st;
    logic                            em_last;

    logic                            out_free;
    logic                            id_ok;
    logic [XW-1:0]                   ptr_x;
    logic [XW-1:0]                   cnt_x;
    logic                            prev_ok;
    logic                            next_ok;
    stq_pkg::mode_t                  req_mode;

    assign out_free = !ov_reg || rsp.ready;
    assign id_ok    = (32'(req.timer_id) < NUM_TIMERS);
    assign ptr_x    = XW'(ptr_reg);
    assign cnt_x    = XW'(cnt_reg);
    assign req_mode = stq_pkg::mode_t'(req.mode);
    assign req.ready = (state_reg == stq_pkg::ST_IDLE);

    assign prev_ok = (ptr_reg == '0) || (prev_exp_reg <= exp_reg);
    assign next_ok = !((ptr_x + XW'(1)) < cnt_x) || (exp_reg <= ram_rdata.expiry);

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        id_next       = id_reg;
        exp_next      = exp_reg;
        now_next      = now_reg;
        prev_exp_next = prev_exp_reg;
        ptr_next      = ptr_reg;
        cnt_next      = cnt_reg;
        act_next      = act_reg;
        pops_next     = pops_reg;
        pend_id_next  = pend_id_reg;
        st_next       = st_reg;

        ram_we        = 1'b0;
        ram_waddr     = ptr_reg;
        ram_wdata     = '{id: id_reg, expiry: exp_reg};
        ram_re        = 1'b0;
        ram_raddr     = ptr_reg;

        emit          = 1'b0;
        em_id         = id_reg;
        em_exp        = 1'b0;
        em_st         = st_reg;
        em_last       = 1'b1;

        case (state_reg)
            stq_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next = req_mode;
                    id_next   = req.timer_id;
                    exp_next  = req.expire_time;
                    now_next  = req.now;
                    st_next   = 1'b0;
                    case (req_mode)
                        stq_pkg::MODE_TICK:
                        begin
                            pops_next  = '0;
                            state_next = stq_pkg::ST_TK_HEAD;
                        end
                        stq_pkg::MODE_ADD:
                        begin
                            if (!id_ok || act_reg[req.timer_id])
                            begin
                                st_next    = 1'b1;
                                state_next = stq_pkg::ST_RESP;
                            end
                            else
                            begin
                                act_next[req.timer_id] = 1'b1;
                                ptr_next   = cnt_reg[AW-1:0];
                                state_next = stq_pkg::ST_INS_RD;
                            end
                        end
                        default:
                        begin
                            if (!id_ok || !act_reg[req.timer_id])
                            begin
                                st_next    = 1'b1;
                                state_next = stq_pkg::ST_RESP;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                state_next = stq_pkg::ST_FIND;
                            end
                        end
                    endcase
                end
            end

            stq_pkg::ST_FIND:
            begin
                ram_re    = 1'b1;
                ram_raddr = ptr_reg + AW'(1);
                if (ram_rdata.id == id_reg)
                begin
                    if (mode_reg == stq_pkg::MODE_ADJUST)
                    begin
                        state_next = stq_pkg::ST_ADJ_CHK;
                    end
                    else
                    begin
                        act_next[id_reg] = 1'b0;
                        state_next = stq_pkg::ST_RM_RD;
                    end
                end
                else
                begin
                    prev_exp_next = ram_rdata.expiry;
                    ptr_next      = ptr_reg + AW'(1);
                end
            end

            stq_pkg::ST_ADJ_CHK:
            begin
                if (prev_ok && next_ok)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = ptr_reg;
                    state_next = stq_pkg::ST_RESP;
                end
                else
                begin
                    state_next = stq_pkg::ST_RM_RD;
                end
            end

            stq_pkg::ST_RM_RD, stq_pkg::ST_RM_MV:
            begin
                if (state_reg == stq_pkg::ST_RM_MV)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ptr_reg;
                    ram_wdata = ram_rdata;
                    ptr_next  = ptr_reg + AW'(1);
                end
                if ((state_reg == stq_pkg::ST_RM_RD) && ((ptr_x + XW'(1)) < cnt_x))
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = ptr_reg + AW'(1);
                    state_next = stq_pkg::ST_RM_MV;
                end
                else if ((state_reg == stq_pkg::ST_RM_MV) && ((ptr_x + XW'(2)) < cnt_x))
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg + AW'(1) + AW'(1);
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                    case (mode_reg)
                        stq_pkg::MODE_ADJUST:
                        begin
                            ptr_next   = AW'(cnt_reg - CW'(1));
                            state_next = stq_pkg::ST_INS_RD;
                        end
                        stq_pkg::MODE_TICK:
                        begin
                            state_next = stq_pkg::ST_TK_HEAD;
                        end
                        default:
                        begin
                            state_next = stq_pkg::ST_RESP;
                        end
                    endcase
                end
            end

            stq_pkg::ST_INS_RD:
            begin
                if (ptr_reg == '0)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = stq_pkg::ST_RESP;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = ptr_reg - AW'(1);
                    state_next = stq_pkg::ST_INS_CMP;
                end
            end

            stq_pkg::ST_INS_CMP:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                if (ram_rdata.expiry > exp_reg)
                begin
                    ram_wdata = ram_rdata;
                    ptr_next  = ptr_reg - AW'(1);
                    if (ptr_reg == AW'(1))
                    begin
                        state_next = stq_pkg::ST_INS_RD;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = ptr_reg - AW'(1) - AW'(1);
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = stq_pkg::ST_RESP;
                end
            end

            stq_pkg::ST_TK_HEAD, stq_pkg::ST_TK_CHK:
            begin
                if (((state_reg == stq_pkg::ST_TK_HEAD) &&
                     ((cnt_reg == '0) ||
                      (pops_reg == stq_pkg::POP_W'(stq_pkg::MAX_RESULTS)))) ||
                    ((state_reg == stq_pkg::ST_TK_CHK) && (ram_rdata.expiry > now_reg)))
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        em_st      = 1'b0;
                        em_last    = 1'b1;
                        em_exp     = (pops_reg != '0);
                        em_id      = (pops_reg != '0) ? pend_id_reg : '0;
                        state_next = stq_pkg::ST_IDLE;
                    end
                end
                else if (state_reg == stq_pkg::ST_TK_HEAD)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = '0;
                    state_next = stq_pkg::ST_TK_CHK;
                end
                else if ((pops_reg == '0) || out_free)
                begin
                    emit         = (pops_reg != '0);
                    em_id        = pend_id_reg;
                    em_exp       = 1'b1;
                    em_st        = 1'b0;
                    em_last      = 1'b0;
                    pend_id_next = ram_rdata.id;
                    pops_next    = pops_reg + stq_pkg::POP_W'(1);
                    act_next[ram_rdata.id] = 1'b0;
                    ptr_next     = '0;
                    state_next   = stq_pkg::ST_RM_RD;
                end
            end

            stq_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = stq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = stq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stq_pkg::ST_IDLE;
            cnt_reg   <= '0;
            act_reg   <= '0;
            pops_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            act_reg   <= act_next;
            pops_reg  <= pops_next;
            if (emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        id_reg       <= id_next;
        exp_reg      <= exp_next;
        now_reg      <= now_next;
        prev_exp_reg <= prev_exp_next;
        ptr_reg      <= ptr_next;
        pend_id_reg  <= pend_id_next;
        st_reg       <= st_next;
        if (emit)
        begin
            o_id_reg   <= em_id;
            o_exp_reg  <= em_exp;
            o_st_reg   <= em_st;
            o_last_reg <= em_last;
        end
    end

    assign rsp.valid     = ov_reg;
    assign rsp.result_id = o_id_reg;
    assign rsp.expired   = o_exp_reg;
    assign rsp.status    = o_st_reg;
    assign rsp.last      = o_last_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sorted_timer_queue_unit.sv @@
// Sorted timer queue: up to NUM_TIMERS timers kept in ascending expiry order.
// Requests arrive on req (mode, timer_id, expire_time, now); every request
// gives one or more result words on rsp, the final one marked by last.
// Add, adjust and delete return one word echoing timer_id with status set
// when the slot state does not allow the operation. Tick returns one word per
// expired timer, oldest expiry first, at most sixteen per tick, or a single
// word with expired clear when nothing is due.
// One request is worked on at a time; req.ready is high only between requests.
// The ordered list lives in a memory with a registered read port and a
// sequencer walks it one entry per cycle, but a tick holds its walk while
// the output register is still full.
// Results sit in an output register, so a request is accepted while the last
// word of the previous one still waits; when rsp.ready is low the sequencer
// holds at its next word until the register frees up.
// Reset clears the active flags, the entry count and the output valid flag;
// the list memory needs no clearing as only entries below the count are used.
`default_nettype none

`include "sorted_timer_queue_unit_defines.svh"

module sorted_timer_queue_unit #(
    parameter int NUM_TIMERS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    stq_req_if.sink     req,
    stq_rsp_if.source   rsp
);

    localparam int AW = $clog2(NUM_TIMERS);

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    stq_pkg::entry_t    ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    stq_pkg::entry_t    ram_rdata;

    stq_list_ram #(
        .DEPTH (NUM_TIMERS),
        .AW    (AW)
    ) u_list_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    stq_seq #(
        .NUM_TIMERS (NUM_TIMERS),
        .AW         (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    `STQ_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "request accepted while busy")
    `STQ_ASSERT_SAME(a_no_rw_collision, ram_we && ram_re, ram_waddr != ram_raddr, "list read and write hit one entry")
    `STQ_ASSERT_SAME(a_expired_ok, rsp.valid && rsp.expired, !rsp.status, "expired word carries error status")
    `STQ_ASSERT_SAME(a_plain_is_last, rsp.valid && !rsp.expired, rsp.last, "non-expiry word is not the last")

endmodule

`default_nettype wire
